// ===== design/tf_idf_weight_unit_defines.svh =====
// Assertion macros for the tf-idf weight unit.
// Both expect clk and arst_n in the scope of use.
`ifndef TF_IDF_WEIGHT_UNIT_DEFINES_SVH
`define TF_IDF_WEIGHT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define TFIDF_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfidf: implication check failed");

// Condition must never be seen
`define TFIDF_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tfidf: forbidden condition seen");

`else

`define TFIDF_ASSERT_IMPLIES(lbl, ante, cons)
`define TFIDF_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== design/tfidf_pkg.sv =====
package tfidf_pkg;

	// Field widths
	localparam int TF_BITS      = 24;
	localparam int COUNT_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int CFG_BITS     = 32;
	localparam int CFG_IDX_BITS = 2;
	localparam int TF_W_BITS    = 56;
	localparam int IDF_W_BITS   = FRAC_BITS + 1;

	// Logarithm unit: Q.32 result, Q1.31 mantissa, exponent up to the wide operand
	localparam int LOG_FRAC     = 32;
	localparam int MANT_BITS    = 32;
	localparam int WIDE_BITS    = 2 * COUNT_BITS + 1;
	localparam int LOG_EXP_BITS = 7;
	localparam int LOG_BITS     = LOG_EXP_BITS + LOG_FRAC;

	// Ratio stage
	localparam int DEN_BITS     = 50;
	localparam int RATIO_BITS   = 40;
	localparam int SHIFT_BITS   = 4;
	localparam int QUO_BITS     = FRAC_BITS + 1;
	localparam int DIV_STAGES   = QUO_BITS;

	// Pipeline length: logarithm steps, four combine stages, divider steps
	localparam int SIDE_LEN     = LOG_FRAC + 4 + DIV_STAGES;
	localparam int LATENCY      = SIDE_LEN + 4;

	localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
	localparam logic [IDF_W_BITS-1:0] ONE_FIX = IDF_W_BITS'(1) << FRAC_BITS;
	localparam logic [LOG_BITS-1:0] LOG_BASE = LOG_BITS'(FRAC_BITS) << LOG_FRAC;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_TF_OFFSET,
		CFG_TF_GAIN,
		CFG_IDF_SMOOTHING,
		CFG_IDF_VARIANT
	} cfg_reg_t;

	typedef struct packed {
		logic [TF_BITS-1:0]    term_frequency;
		logic [COUNT_BITS-1:0] document_frequency;
		logic [COUNT_BITS-1:0] total_documents;
	} in_t;

	typedef struct packed {
		logic [TF_W_BITS-1:0]  tf_weight;
		logic [IDF_W_BITS-1:0] idf_weight;
		logic                  idf_error;
	} out_t;

	typedef struct packed {
		logic [LOG_EXP_BITS-1:0] exp;
		logic [MANT_BITS-1:0]    mant;
	} lg_norm_t;

	typedef struct packed {
		logic                 is_one;
		logic                 bad;
		logic [TF_W_BITS-1:0] tfw;
	} side_t;

	// Index of the top set bit, zero for a zero operand
	function automatic logic [LOG_EXP_BITS-1:0] top_bit(input logic [WIDE_BITS-1:0] v);
		logic [LOG_EXP_BITS-1:0] e;
		e = '0;
		for (int i = 0; i < WIDE_BITS; i++) begin
			if (v[i])
				e = LOG_EXP_BITS'(i);
		end
		return e;
	endfunction

	// Split into exponent and truncated Q1.31 mantissa
	function automatic lg_norm_t lg_norm(input logic [WIDE_BITS-1:0] v);
		logic [WIDE_BITS+MANT_BITS-2:0] w;
		lg_norm_t r;
		r.exp = top_bit(v);
		w = {v, {(MANT_BITS-1){1'b0}}} >> r.exp;
		r.mant = w[MANT_BITS-1:0];
		return r;
	endfunction

endpackage

// ===== design/tfidf_log2.sv =====
module tfidf_log2 import tfidf_pkg::*; (
	input  logic                clk,
	input  lg_norm_t            norm,
	output logic [LOG_BITS-1:0] log_val
);

	logic [MANT_BITS-1:0]    mant_s [LOG_FRAC];
	logic [LOG_FRAC-1:0]     frac_s [LOG_FRAC];
	logic [LOG_EXP_BITS-1:0] exp_s  [LOG_FRAC];
	logic [MANT_BITS-1:0]    mant_d [LOG_FRAC];
	logic [LOG_FRAC-1:0]     frac_d [LOG_FRAC];

	// Square the mantissa once per stage, emit one fraction bit
	always_comb begin
		logic [MANT_BITS-1:0]   m_in;
		logic [LOG_FRAC-1:0]    f_in;
		logic [2*MANT_BITS-1:0] sq;
		logic [MANT_BITS:0]     t;
		for (int i = 0; i < LOG_FRAC; i++) begin
			m_in = (i == 0) ? norm.mant : mant_s[(i == 0) ? 0 : i - 1];
			f_in = (i == 0) ? '0 : frac_s[(i == 0) ? 0 : i - 1];
			sq = (2*MANT_BITS)'(m_in) * (2*MANT_BITS)'(m_in);
			t = sq[2*MANT_BITS-1:MANT_BITS-1];
			if (t[MANT_BITS]) begin
				mant_d[i] = t[MANT_BITS:1];
				frac_d[i] = {f_in[LOG_FRAC-2:0], 1'b1};
			end else begin
				mant_d[i] = t[MANT_BITS-1:0];
				frac_d[i] = {f_in[LOG_FRAC-2:0], 1'b0};
			end
		end
	end

	// Advance the squaring chain and carry the exponent
	always_ff @(posedge clk) begin
		for (int i = 0; i < LOG_FRAC; i++) begin
			mant_s[i] <= mant_d[i];
			frac_s[i] <= frac_d[i];
			exp_s[i] <= (i == 0) ? norm.exp : exp_s[(i == 0) ? 0 : i - 1];
		end
	end

	assign log_val = {exp_s[LOG_FRAC-1], frac_s[LOG_FRAC-1]};

endmodule

// ===== design/tf_idf_weight_unit.sv =====
// Channel   Handshake          Payload
// input     start / busy       request (in_t)
// result    done (one cycle)   result (out_t)
// config    cfg_we             cfg_index, cfg_data
//
// One beat is taken in every cycle; busy stays low.
// From the accepting edge to the edge that takes the result, a beat passes through
// three input stages, the 32-step squaring chain of the logarithm units, four
// combine stages, the 17-step restoring divider and the output register.
// Reset clears the valid line and loads the register defaults.
// Results leave on the done strobe; the receiver cannot stall the pipeline.
`include "tf_idf_weight_unit_defines.svh"

module tf_idf_weight_unit import tfidf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  in_t                     request,
	output logic                    done,
	output out_t                    result,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	logic [CFG_BITS-1:0] tf_offset_q;
	logic [CFG_BITS-1:0] tf_gain_q;
	logic [CFG_BITS-1:0] idf_smoothing_q;
	logic                idf_variant_q;
	logic [DEN_BITS-1:0] xl_q;

	logic                          valid_s1, valid_s2, valid_s3;
	logic [TF_W_BITS-1:0]          tf_prod_s1;
	logic [2*COUNT_BITS-1:0]       xn_s1;
	logic [COUNT_BITS-1:0]         df_s1, n_s1;
	logic                          is_one_s1, bad_s1;
	logic [WIDE_BITS-1:0]          lane0_s2, lane1_s2, lane2_s2;
	side_t                         side_s2, side_s3;
	lg_norm_t                      norm0_s3, norm1_s3, norm2_s3;
	logic [LOG_BITS-1:0]           log0, log1, log2;
	logic [SIDE_LEN-1:0]           vld_line_s;
	side_t                         side_line_s [SIDE_LEN];
	logic [DEN_BITS-1:0]           den_s36, minu_s36, subt_s36;
	logic [DEN_BITS-1:0]           num_s37, den_s37, num_s38, den_s38;
	logic                          dz_s37, dz_s38, dz_s39;
	logic [RATIO_BITS-1:0]         num_s39, den_s39;
	logic [RATIO_BITS-1:0]         div_r_s [DIV_STAGES];
	logic [RATIO_BITS-1:0]         div_d_s [DIV_STAGES];
	logic [QUO_BITS-1:0]           div_q_s [DIV_STAGES];
	logic                          div_dz_s [DIV_STAGES];
	logic [RATIO_BITS-1:0]         div_r_d [DIV_STAGES];
	logic [QUO_BITS-1:0]           div_q_d [DIV_STAGES];
	logic                          done_q;
	out_t                          result_q;
	logic [TF_W_BITS:0]            tf_sum;
	logic [WIDE_BITS-1:0]          wide_a, wide_b;
	logic [DEN_BITS-1:0]           den_v0;
	logic [LOG_BITS-1:0]           lb_net;
	logic [LOG_EXP_BITS-1:0]       den_top;
	logic [SHIFT_BITS-1:0]         den_shift;
	logic [DEN_BITS-1:0]           xl_hi, xl_lo;
	side_t                         side_end;
	logic                          fail_end;

	assign busy = 1'b0;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_offset_q <= '0;
			tf_gain_q <= CFG_BITS'(ONE_FIX);
			idf_smoothing_q <= '0;
			idf_variant_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TF_OFFSET:     tf_offset_q <= cfg_data;
				CFG_TF_GAIN:       tf_gain_q <= cfg_data;
				CFG_IDF_SMOOTHING: idf_smoothing_q <= cfg_data;
				CFG_IDF_VARIANT:   idf_variant_q <= cfg_data[0];
			endcase
		end
	end

	// Smoothing constant in log2 units, x * log2(e)
	assign xl_hi = DEN_BITS'(idf_smoothing_q[31:16]) * DEN_BITS'(LOG2E_Q32);
	assign xl_lo = DEN_BITS'(idf_smoothing_q[15:0]) * DEN_BITS'(LOG2E_Q32);
	always_ff @(posedge clk) begin
		xl_q <= xl_hi + (xl_lo >> FRAC_BITS);
	end

	// Valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			vld_line_s <= '0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			vld_line_s <= {vld_line_s[SIDE_LEN-2:0], valid_s3};
			done_q <= vld_line_s[SIDE_LEN-1];
		end
	end

	// Stage 1: products and special-case flags
	always_ff @(posedge clk) begin
		tf_prod_s1 <= TF_W_BITS'(tf_gain_q) * TF_W_BITS'(request.term_frequency);
		xn_s1 <= (2*COUNT_BITS)'(idf_smoothing_q) * (2*COUNT_BITS)'(request.total_documents);
		df_s1 <= request.document_frequency;
		n_s1 <= request.total_documents;
		is_one_s1 <= idf_variant_q && (idf_smoothing_q == '0);
		bad_s1 <= (request.document_frequency == '0) || (request.total_documents == '0);
	end

	// Stage 2: saturate tf weight, form the wide log operands
	assign tf_sum = (TF_W_BITS+1)'(tf_prod_s1) + (TF_W_BITS+1)'(tf_offset_q);
	assign wide_a = WIDE_BITS'(xn_s1) + (WIDE_BITS'(df_s1) << FRAC_BITS);
	assign wide_b = WIDE_BITS'(xn_s1) + WIDE_BITS'(ONE_FIX);

	always_ff @(posedge clk) begin
		lane0_s2 <= idf_variant_q ? wide_a : WIDE_BITS'(n_s1);
		lane1_s2 <= WIDE_BITS'(df_s1);
		lane2_s2 <= wide_b;
		side_s2.is_one <= is_one_s1;
		side_s2.bad <= bad_s1;
		side_s2.tfw <= tf_sum[TF_W_BITS] ? '1 : tf_sum[TF_W_BITS-1:0];
	end

	// Stage 3: normalise to exponent and mantissa
	always_ff @(posedge clk) begin
		norm0_s3 <= lg_norm(lane0_s2);
		norm1_s3 <= lg_norm(lane1_s2);
		norm2_s3 <= lg_norm(lane2_s2);
		side_s3 <= side_s2;
	end

	tfidf_log2 u_log0 (.clk(clk), .norm(norm0_s3), .log_val(log0));
	tfidf_log2 u_log1 (.clk(clk), .norm(norm1_s3), .log_val(log1));
	tfidf_log2 u_log2 (.clk(clk), .norm(norm2_s3), .log_val(log2));

	// Carry tf weight and flags beside the logarithm and divider stages
	always_ff @(posedge clk) begin
		for (int i = 0; i < SIDE_LEN; i++)
			side_line_s[i] <= (i == 0) ? side_s3 : side_line_s[(i == 0) ? 0 : i - 1];
	end

	// Stage 36: pick numerator terms and denominator for the variant
	assign den_v0 = xl_q + DEN_BITS'(log0);
	assign lb_net = (log2 > LOG_BASE) ? log2 - LOG_BASE : '0;

	always_ff @(posedge clk) begin
		den_s36 <= idf_variant_q ? DEN_BITS'(lb_net) : den_v0;
		minu_s36 <= idf_variant_q ? DEN_BITS'(log0) : den_v0;
		subt_s36 <= idf_variant_q ? DEN_BITS'(log1) + DEN_BITS'(LOG_BASE) : DEN_BITS'(log1);
	end

	// Stage 37: numerator, clamped at zero
	always_ff @(posedge clk) begin
		num_s37 <= (minu_s36 > subt_s36) ? minu_s36 - subt_s36 : '0;
		den_s37 <= den_s36;
		dz_s37 <= (den_s36 == '0);
	end

	// Stage 38: clamp numerator to denominator
	always_ff @(posedge clk) begin
		num_s38 <= (num_s37 > den_s37) ? den_s37 : num_s37;
		den_s38 <= den_s37;
		dz_s38 <= dz_s37;
	end

	// Stage 39: shift both until the denominator fits the divider
	assign den_top = top_bit(WIDE_BITS'(den_s38));
	assign den_shift = (den_top >= LOG_EXP_BITS'(RATIO_BITS)) ?
		SHIFT_BITS'(den_top - LOG_EXP_BITS'(RATIO_BITS - 1)) : '0;

	always_ff @(posedge clk) begin
		num_s39 <= RATIO_BITS'(num_s38 >> den_shift);
		den_s39 <= RATIO_BITS'(den_s38 >> den_shift);
		dz_s39 <= dz_s38;
	end

	// Stages 40 to 56: one quotient bit per stage
	always_comb begin
		logic [RATIO_BITS:0]   r_in;
		logic [RATIO_BITS-1:0] d_in;
		logic [QUO_BITS-1:0]   q_in;
		for (int j = 0; j < DIV_STAGES; j++) begin
			if (j == 0) begin
				r_in = (RATIO_BITS+1)'(num_s39);
				d_in = den_s39;
				q_in = '0;
			end else begin
				r_in = {div_r_s[(j == 0) ? 0 : j - 1], 1'b0};
				d_in = div_d_s[(j == 0) ? 0 : j - 1];
				q_in = div_q_s[(j == 0) ? 0 : j - 1];
			end
			if (r_in >= (RATIO_BITS+1)'(d_in)) begin
				div_r_d[j] = RATIO_BITS'(r_in - (RATIO_BITS+1)'(d_in));
				div_q_d[j] = {q_in[QUO_BITS-2:0], 1'b1};
			end else begin
				div_r_d[j] = RATIO_BITS'(r_in);
				div_q_d[j] = {q_in[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_STAGES; j++) begin
			div_r_s[j] <= div_r_d[j];
			div_q_s[j] <= div_q_d[j];
			div_d_s[j] <= (j == 0) ? den_s39 : div_d_s[(j == 0) ? 0 : j - 1];
			div_dz_s[j] <= (j == 0) ? dz_s39 : div_dz_s[(j == 0) ? 0 : j - 1];
		end
	end

	// Stage 57: apply special cases, hold result for one beat
	assign side_end = side_line_s[SIDE_LEN-1];
	assign fail_end = side_end.bad || div_dz_s[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		result_q.tf_weight <= side_end.tfw;
		if (side_end.is_one) begin
			result_q.idf_weight <= ONE_FIX;
			result_q.idf_error <= 1'b0;
		end else if (fail_end) begin
			result_q.idf_weight <= '0;
			result_q.idf_error <= 1'b1;
		end else begin
			result_q.idf_weight <= div_q_s[DIV_STAGES-1];
			result_q.idf_error <= 1'b0;
		end
	end

	assign done = done_q;
	assign result = result_q;

	`TFIDF_ASSERT_IMPLIES(a_done_latency, done, $past(start, LATENCY))
	`TFIDF_ASSERT_IMPLIES(a_idf_range, done, result.idf_weight <= ONE_FIX)
	`TFIDF_ASSERT_IMPLIES(a_err_zero, done && result.idf_error, result.idf_weight == '0)

endmodule
